// ----- src/riff_wave_chunk_locator_core_macros.svh -----
// Assertion macros shared by the RIFF/WAVE chunk locator RTL.
`ifndef RIFF_WAVE_CHUNK_LOCATOR_CORE_MACROS_SVH
`define RIFF_WAVE_CHUNK_LOCATOR_CORE_MACROS_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define RWCL_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the next cycle.
`define RWCL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/rwcl_pkg.sv -----
// Types and constants of the RIFF/WAVE chunk locator.
`default_nettype none

package rwcl_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_MIN_LEN = 32'd14;

    localparam int POS_W = 34;

    // Configuration register indexes
    localparam logic CFG_WANT_FORMAT = 1'b0;
    localparam logic CFG_WANT_DATA   = 1'b1;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_CHUNK  = 4'b0010,
        PH_SKIP   = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_RIFF  = 3'd1,
        ST_FMT_SHORT = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_TRUNCATED = 3'd4
    } status_t;

    typedef struct packed {
        logic        fire;
        status_t     status;
        logic        format_found;
        logic [31:0] format_offset;
        logic        data_found;
        logic [31:0] data_offset;
        logic [31:0] data_size;
    } result_t;

endpackage

`default_nettype wire

// ----- src/rwcl_walker.sv -----
// Byte-at-a-time RIFF/WAVE header and chunk walker.
`default_nettype none

module rwcl_walker
    import rwcl_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_fire,
    input  wire logic [7:0] file_byte,
    input  wire logic       last_byte,
    input  wire logic       want_format,
    input  wire logic       want_data,
    output result_t         res
);

    phase_t             phase_reg,      phase_next;
    logic [POS_W-1:0]   pos_reg,        pos_next;
    logic [31:0]        ws_reg,         ws_next;
    logic [31:0]        tag_reg,        tag_next;
    logic [POS_W-1:0]   riff_end_reg,   riff_end_next;
    logic [POS_W-1:0]   skip_end_reg,   skip_end_next;
    logic [2:0]         hdr_cnt_reg,    hdr_cnt_next;
    logic               fmt_seen_reg,   fmt_seen_next;
    logic [31:0]        fmt_off_reg,    fmt_off_next;
    logic               data_seen_reg,  data_seen_next;
    logic [31:0]        data_off_reg,   data_off_next;
    logic [31:0]        data_size_reg,  data_size_next;

    logic [31:0]        ws_shift;
    logic [POS_W-1:0]   pos_inc;
    logic               decide;
    logic               start;
    status_t            st;

    always_comb begin
        ws_shift       = {file_byte, ws_reg[31:8]};
        pos_inc        = pos_reg + {{(POS_W-1){1'b0}}, 1'b1};
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        ws_next        = ws_reg;
        tag_next       = tag_reg;
        riff_end_next  = riff_end_reg;
        skip_end_next  = skip_end_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        fmt_seen_next  = fmt_seen_reg;
        fmt_off_next   = fmt_off_reg;
        data_seen_next = data_seen_reg;
        data_off_next  = data_off_reg;
        data_size_next = data_size_reg;
        decide         = 1'b0;
        start          = 1'b0;
        st             = ST_OK;

        if (phase_reg != PH_DONE) begin
            ws_next  = ws_shift;
            pos_next = pos_inc;
        end

        unique case (phase_reg)
            PH_HEADER: begin
                // Header bytes 0..11: RIFF tag, RIFF length, WAVE tag
                if (pos_reg[3:0] == 4'd3) begin
                    tag_next = ws_shift;
                end else if (pos_reg[3:0] == 4'd7) begin
                    riff_end_next = {2'b00, ws_shift} + POS_W'(8);
                end else if (pos_reg[3:0] == 4'd11) begin
                    if (ws_shift != TAG_WAVE || tag_reg != TAG_RIFF) begin
                        decide = 1'b1;
                        st     = ST_NOT_RIFF;
                    end else begin
                        start = 1'b1;
                    end
                end
            end
            PH_CHUNK: begin
                hdr_cnt_next = hdr_cnt_reg + 3'd1;
                if (hdr_cnt_reg == 3'd3) begin
                    tag_next = ws_shift;
                end else if (hdr_cnt_reg == 3'd7) begin
                    if (tag_reg == TAG_FMT && want_format && !fmt_seen_reg) begin
                        if (ws_shift < FMT_MIN_LEN) begin
                            decide = 1'b1;
                            st     = ST_FMT_SHORT;
                        end else begin
                            fmt_seen_next = 1'b1;
                            fmt_off_next  = pos_inc[31:0];
                            if (!want_data || data_seen_reg) begin
                                decide = 1'b1;
                            end
                        end
                    end else if (tag_reg == TAG_DATA && want_data && !data_seen_reg
                                 && ws_shift != 32'd0) begin
                        data_seen_next = 1'b1;
                        data_off_next  = pos_inc[31:0];
                        data_size_next = ws_shift;
                        if (!want_format || fmt_seen_reg) begin
                            decide = 1'b1;
                        end
                    end
                    if (!decide) begin
                        // Body padded to even length: len + (len & 1)
                        phase_next    = PH_SKIP;
                        skip_end_next = pos_reg + {2'b00, ws_shift}
                                      + {{(POS_W-1){1'b0}}, ws_shift[0]}
                                      + {{(POS_W-1){1'b0}}, 1'b1};
                        start         = (ws_shift == 32'd0);
                    end
                end
            end
            PH_SKIP: begin
                start = (pos_inc >= skip_end_reg);
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase

        // A new chunk header may begin only before the RIFF end
        if (start) begin
            if (pos_inc >= riff_end_next) begin
                decide = 1'b1;
                st     = ST_NOT_FOUND;
            end else begin
                phase_next   = PH_CHUNK;
                hdr_cnt_next = 3'd0;
            end
        end

        if (decide) begin
            phase_next = PH_DONE;
        end

        res.fire          = in_fire && (phase_reg != PH_DONE) && (decide || last_byte);
        res.status        = decide ? st : ST_TRUNCATED;
        res.format_found  = fmt_seen_next;
        res.format_offset = fmt_off_next;
        res.data_found    = data_seen_next;
        res.data_offset   = data_off_next;
        res.data_size     = data_size_next;

        if (last_byte) begin
            phase_next     = PH_HEADER;
            pos_next       = '0;
            ws_next        = '0;
            tag_next       = '0;
            riff_end_next  = '0;
            skip_end_next  = '0;
            hdr_cnt_next   = '0;
            fmt_seen_next  = 1'b0;
            fmt_off_next   = '0;
            data_seen_next = 1'b0;
            data_off_next  = '0;
            data_size_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            pos_reg       <= '0;
            ws_reg        <= '0;
            tag_reg       <= '0;
            riff_end_reg  <= '0;
            skip_end_reg  <= '0;
            hdr_cnt_reg   <= '0;
            fmt_seen_reg  <= 1'b0;
            fmt_off_reg   <= '0;
            data_seen_reg <= 1'b0;
            data_off_reg  <= '0;
            data_size_reg <= '0;
        end else if (in_fire) begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            ws_reg        <= ws_next;
            tag_reg       <= tag_next;
            riff_end_reg  <= riff_end_next;
            skip_end_reg  <= skip_end_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            fmt_seen_reg  <= fmt_seen_next;
            fmt_off_reg   <= fmt_off_next;
            data_seen_reg <= data_seen_next;
            data_off_reg  <= data_off_next;
            data_size_reg <= data_size_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/riff_wave_chunk_locator_core.sv -----
// Top level of the RIFF/WAVE chunk locator: channels, configuration and result register.
//
// Usage: stream a WAV file in on the s_ channel, one byte per item, with
// s_last_byte set on the final byte. The block checks the RIFF/WAVE tags, walks
// the chunk headers and gives at most one result item per file on the m_
// channel: a status plus the fmt body offset and the data body offset and size.
// The deciding byte's result appears on m_ in the cycle after the byte is
// accepted. Throughput: one byte per cycle while s_ready is high, set by the
// walker's single registered next-state pass (a 34-bit add and compare per
// byte). Bytes after the decision are taken at full rate and dropped up to the
// last byte; the last byte clears the parse state for the next file.
// Stall: the result sits in an output register; s_ready drops for as long as
// a result waits there with m_ready low, whether or not the next byte would
// decide, and rises again in the cycle that m_ready takes the result.
// Configuration: cfg_index 0 is want_format, 1 is want_data; both reset to 1.
// cfg_ready is always high. Reset (aresetn low, synchronous) clears the parse
// state and the output valid flag and sets both want registers to 1.
`default_nettype none

module riff_wave_chunk_locator_core
    import rwcl_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // byte stream in
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_file_byte,
    input  wire logic        s_last_byte,
    // result out
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic             m_format_found,
    output logic [31:0]      m_format_offset,
    output logic             m_data_found,
    output logic [31:0]      m_data_offset,
    output logic [31:0]      m_data_size,
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic        cfg_data
);

`include "riff_wave_chunk_locator_core_macros.svh"

    logic    want_format_reg;
    logic    want_data_reg;
    logic    in_fire;
    result_t res;
    logic    m_valid_reg;
    result_t out_reg;

    // Configuration writes land at once; nothing to stall on
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            want_format_reg <= 1'b1;
            want_data_reg   <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_WANT_FORMAT: want_format_reg <= cfg_data;
                CFG_WANT_DATA:   want_data_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Hold input only when a pending result cannot drain this cycle
    assign s_ready = !m_valid_reg || m_ready;
    assign in_fire = s_valid && s_ready;

    rwcl_walker u_walker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .file_byte   (s_file_byte),
        .last_byte   (s_last_byte),
        .want_format (want_format_reg),
        .want_data   (want_data_reg),
        .res         (res)
    );

    // Result register: load on a deciding or last byte, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res.fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.fire) begin
            out_reg <= res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = out_reg.status;
    assign m_format_found  = out_reg.format_found;
    assign m_format_offset = out_reg.format_offset;
    assign m_data_found    = out_reg.data_found;
    assign m_data_offset   = out_reg.data_offset;
    assign m_data_size     = out_reg.data_size;

    `RWCL_ASSERT_IMPLY(a_ready_when_empty, !m_valid_reg, s_ready, "input stalled with empty result register")
    `RWCL_ASSERT_NEXT(a_fire_loads_result, res.fire, m_valid_reg, "decided result not presented")
    `RWCL_ASSERT_IMPLY(a_ok_has_chunk, m_valid_reg && m_status == ST_OK, m_format_found || m_data_found, "ok status with nothing located")
    `RWCL_ASSERT_IMPLY(a_no_data_zero, m_valid_reg && !m_data_found, m_data_offset == 32'd0 && m_data_size == 32'd0, "data fields set without a data chunk")

endmodule

`default_nettype wire

// ----- verif/riff_wave_chunk_locator_core_tb.sv -----
// Self-checking testbench for the RIFF/WAVE chunk locator core.
`timescale 1ns / 100ps

module riff_wave_chunk_locator_core_tb;
    import rwcl_pkg::*;

    // Expected content of one result item.
    typedef struct {
        status_t     status;
        logic        format_found;
        logic [31:0] format_offset;
        logic        data_found;
        logic [31:0] data_offset;
        logic [31:0] data_size;
    } verdict_t;

    localparam int SETTLE_CYCLES = 4;     // result lands in the cycle after its byte
    localparam int DRAIN_LIMIT   = 2000;  // covers the long receiver hold-off
    localparam int PRINT_LIMIT   = 40;

    // Clock, reset and every block input start at a known value.
    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_file_byte = 8'h00;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [2:0]  m_status;
    logic        m_format_found;
    logic [31:0] m_format_offset;
    logic        m_data_found;
    logic [31:0] m_data_offset;
    logic [31:0] m_data_size;
    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    logic        cfg_index   = CFG_WANT_FORMAT;
    logic        cfg_data    = 1'b0;

    riff_wave_chunk_locator_core u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_file_byte     (s_file_byte),
        .s_last_byte     (s_last_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_format_found  (m_format_found),
        .m_format_offset (m_format_offset),
        .m_data_found    (m_data_found),
        .m_data_offset   (m_data_offset),
        .m_data_size     (m_data_size),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor: a private copy of the walker state and the two want bits.
    // ------------------------------------------------------------------
    logic        use_fmt   = 1'b1;
    logic        use_data  = 1'b1;
    phase_t      walk_phase = PH_HEADER;
    logic [33:0] walk_pos  = '0;
    logic [31:0] last_word = '0;
    logic [31:0] cur_tag   = '0;
    logic [33:0] walk_end  = '0;
    logic [33:0] skip_to   = '0;
    logic        fmt_hit   = 1'b0;
    logic [31:0] fmt_at    = '0;
    logic        data_hit  = 1'b0;
    logic [31:0] data_at   = '0;
    logic [31:0] data_len  = '0;

    verdict_t    verdict_q[$];   // results still owed by the block

    // Bookkeeping for the summary and the end of run.
    int failures       = 0;
    int bytes_sent     = 0;
    int files_played   = 0;
    int verdicts_due   = 0;
    int verdicts_seen  = 0;
    int settings_used  = 0;
    int status_tally[5];

    // Idling controls shared between the test sequence and the two sides.
    bit src_calm = 1'b0;
    bit dst_calm = 1'b0;
    int rx_hold  = 0;

    logic [7:0] wav_bytes[$];    // file being assembled for the next play

    function automatic void forget_file();
        walk_phase = PH_HEADER;
        walk_pos   = '0;
        last_word  = '0;
        cur_tag    = '0;
        walk_end   = '0;
        skip_to    = '0;
        fmt_hit    = 1'b0;
        fmt_at     = '0;
        data_hit   = 1'b0;
        data_at    = '0;
        data_len   = '0;
    endfunction

    // At a chunk boundary: report the end of the walk, or open the next header.
    function automatic bit chunk_walk_ends();
        if (walk_pos >= walk_end) return 1'b1;
        walk_phase = PH_CHUNK;
        skip_to    = walk_pos + 34'd8;
        return 1'b0;
    endfunction

    function automatic verdict_t snapshot(status_t code);
        verdict_t v;
        v.status        = code;
        v.format_found  = fmt_hit;
        v.format_offset = fmt_at;
        v.data_found    = data_hit;
        v.data_offset   = data_at;
        v.data_size     = data_len;
        return v;
    endfunction

    // Advance the walker by one byte; returns 1 when a result item is due.
    function automatic bit locate_byte(input logic [7:0] b, input logic last,
                                       output verdict_t v);
        logic [33:0] at;
        logic [33:0] body;
        logic [31:0] len;
        bit          hit;
        bit          due;
        status_t     code;
        hit  = 1'b0;
        due  = 1'b0;
        code = ST_OK;
        if (walk_phase == PH_DONE) begin
            // Decided already: drop bytes until the end of the file.
            if (last) forget_file();
            return 1'b0;
        end
        last_word = {b, last_word[31:8]};
        at        = walk_pos;
        walk_pos  = at + 34'd1;
        case (walk_phase)
            PH_HEADER: begin
                if (at == 34'd3) begin
                    cur_tag = last_word;
                end else if (at == 34'd7) begin
                    walk_end = {2'b00, last_word} + 34'd8;
                end else if (at == 34'd11) begin
                    if (last_word != TAG_WAVE || cur_tag != TAG_RIFF) begin
                        hit  = 1'b1;
                        code = ST_NOT_RIFF;
                    end else if (chunk_walk_ends()) begin
                        hit  = 1'b1;
                        code = ST_NOT_FOUND;
                    end
                end
            end
            PH_CHUNK: begin
                if (walk_pos + 34'd4 == skip_to) begin
                    cur_tag = last_word;
                end else if (walk_pos == skip_to) begin
                    len  = last_word;
                    body = walk_pos;
                    if (cur_tag == TAG_FMT && use_fmt && !fmt_hit) begin
                        if (len < FMT_MIN_LEN) begin
                            hit  = 1'b1;
                            code = ST_FMT_SHORT;
                        end else begin
                            fmt_hit = 1'b1;
                            fmt_at  = body[31:0];
                            if (!use_data || data_hit) hit = 1'b1;
                        end
                    end else if (cur_tag == TAG_DATA && use_data && !data_hit
                                 && len != 32'd0) begin
                        data_hit = 1'b1;
                        data_at  = body[31:0];
                        data_len = len;
                        if (!use_fmt || fmt_hit) hit = 1'b1;
                    end
                    if (!hit) begin
                        // Skip the body, rounded up to an even length.
                        walk_phase = PH_SKIP;
                        skip_to    = body + (({2'b00, len} + 34'd1) & ~34'd1);
                        if (walk_pos == skip_to && chunk_walk_ends()) begin
                            hit  = 1'b1;
                            code = ST_NOT_FOUND;
                        end
                    end
                end
            end
            default: begin
                if (walk_pos >= skip_to && chunk_walk_ends()) begin
                    hit  = 1'b1;
                    code = ST_NOT_FOUND;
                end
            end
        endcase
        if (hit) begin
            v          = snapshot(code);
            walk_phase = PH_DONE;
            due        = 1'b1;
        end else if (last) begin
            v   = snapshot(ST_TRUNCATED);
            due = 1'b1;
        end
        if (last) forget_file();
        return due;
    endfunction

    // ------------------------------------------------------------------
    // Reporting and result checking.
    // ------------------------------------------------------------------
    task automatic note_failure(input string msg);
        if (failures < PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $time, msg);
        failures++;
    endtask

    task automatic compare_field(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            note_failure($sformatf("result %0d %s: got %0h, expected %0h",
                                   verdicts_seen, field, got, want));
    endtask

    task automatic check_verdict();
        verdict_t e;
        if (m_status <= ST_TRUNCATED) status_tally[m_status]++;
        if (verdict_q.size() == 0) begin
            note_failure($sformatf("result with status %0d arrived, none expected",
                                   m_status));
            return;
        end
        e = verdict_q.pop_front();
        compare_field("status",        {29'd0, m_status},      {29'd0, e.status});
        compare_field("format_found",  {31'd0, m_format_found}, {31'd0, e.format_found});
        compare_field("format_offset", m_format_offset,          e.format_offset);
        compare_field("data_found",    {31'd0, m_data_found},   {31'd0, e.data_found});
        compare_field("data_offset",   m_data_offset,            e.data_offset);
        compare_field("data_size",     m_data_size,              e.data_size);
        verdicts_seen++;
    endtask

    // Result side: random stalls per item, calm stretches, and the long
    // hold-off that the back-pressure test asks for.
    initial begin : result_sink
        int stall;
        bit got;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = dst_calm ? 0 : int'($urandom_range(0, 11));
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            got = 1'b0;
            while (!got) begin
                @(posedge aclk);
                if (m_valid && m_ready) begin
                    got = 1'b1;
                end else if (rx_hold > 0) begin
                    // Hold off for the requested stretch, counted here.
                    m_ready <= 1'b0;
                    repeat (rx_hold) @(posedge aclk);
                    rx_hold = 0;
                    m_ready <= 1'b1;
                end
            end
            check_verdict();
            if ($urandom_range(0, 19) == 0) dst_calm = !dst_calm;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus plumbing.
    // ------------------------------------------------------------------

    // Offer one byte; predict its outcome on the edge that accepts it.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int       gap;
        verdict_t v;
        gap = src_calm ? 0 : int'($urandom_range(0, 11));
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_file_byte <= b;
        s_last_byte <= last;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        if (locate_byte(b, last, v)) begin
            verdict_q.push_back(v);
            verdicts_due++;
        end
    endtask

    // Drop valid, wait for every owed result, then let the pipe settle.
    task automatic settle();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (verdict_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        while (verdict_q.size() != 0) begin
            void'(verdict_q.pop_front());
            note_failure("expected result never arrived");
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write both want registers back to back, keeping valid high between them.
    task automatic apply_settings(input logic fmt_on, input logic data_on);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_WANT_FORMAT;
        cfg_data  <= fmt_on;
        do @(posedge aclk); while (!cfg_ready);
        use_fmt = fmt_on;
        cfg_index <= CFG_WANT_DATA;
        cfg_data  <= data_on;
        do @(posedge aclk); while (!cfg_ready);
        use_data = data_on;
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic void push_le32(input logic [31:0] w);
        for (int i = 0; i < 4; i++) wav_bytes.push_back(w[8*i +: 8]);
    endfunction

    function automatic void start_file(input logic [31:0] riff_tag,
                                       input logic [31:0] riff_len,
                                       input logic [31:0] wave_tag);
        wav_bytes.delete();
        push_le32(riff_tag);
        push_le32(riff_len);
        push_le32(wave_tag);
    endfunction

    function automatic void push_chunk(input logic [31:0] tag, input logic [31:0] len,
                                       input int body_bytes);
        push_le32(tag);
        push_le32(len);
        repeat (body_bytes) wav_bytes.push_back(8'($urandom));
    endfunction

    // Patch the RIFF length so that the walk ends with the bytes present.
    function automatic void seal_riff();
        logic [31:0] n;
        n = 32'(wav_bytes.size() - 8);
        for (int i = 0; i < 4; i++) wav_bytes[4 + i] = n[8*i +: 8];
    endfunction

    task automatic play_file();
        int n;
        n = wav_bytes.size();
        for (int i = 0; i < n; i++) send_byte(wav_bytes[i], i == n - 1);
        files_played++;
    endtask

    // ------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------
    task automatic test_well_formed();
        // plain file, fmt then data
        start_file(TAG_RIFF, 32'd0, TAG_WAVE);
        push_chunk(TAG_FMT, 32'd16, 16);
        push_chunk(TAG_DATA, 32'd4, 4);
        seal_riff();
        play_file();
        // minimum fmt size; the file ends on the deciding byte
        start_file(TAG_RIFF, 32'd0, TAG_WAVE);
        push_chunk(TAG_FMT, FMT_MIN_LEN, 14);
        push_chunk(TAG_DATA, 32'd2, 0);
        seal_riff();
        play_file();
        // data first, fmt last, then trailing bytes at both extremes
        start_file(TAG_RIFF, 32'd0, TAG_WAVE);
        push_chunk(TAG_DATA, 32'd3, 4);
        push_chunk(TAG_FMT, 32'd18, 18);
        seal_riff();
        wav_bytes.push_back(8'h00);
        wav_bytes.push_back(8'hFF);
        play_file();
        settle();
    endtask

    task automatic test_bad_tags();
        start_file(TAG_RIFF ^ 32'h8000_0000, 32'd4, TAG_WAVE);
        play_file();
        start_file(TAG_RIFF, 32'd4, TAG_WAVE ^ 32'h0000_0001);
        wav_bytes.push_back(8'hFF);
        play_file();
        settle();
    endtask

    task automatic test_short_format();
        start_file(TAG_RIFF, 32'd0, TAG_WAVE);
        push_chunk(TAG_FMT, FMT_MIN_LEN - 32'd1, 14);
        push_chunk(TAG_DATA, 32'd2, 2);
        seal_riff();
        play_file();
        settle();
    endtask

    task automatic test_walk_end();
        // RIFF length 4: the walk ends before the first chunk
        start_file(TAG_RIFF, 32'd4, TAG_WAVE);
        push_chunk(TAG_FMT, 32'd16, 16);
        play_file();
        // header that starts before the end is read in full past it
        start_file(TAG_RIFF, 32'd6, TAG_WAVE);
        push_chunk(TAG_FMT, 32'd16, 16);
        push_chunk(TAG_DATA, 32'd2, 2);
        play_file();
        // only an unknown chunk, walk ends cleanly at RIFF length plus 8
        start_file(TAG_RIFF, 32'd0, TAG_WAVE);
        push_chunk(32'h5453_494C, 32'd0, 0);
        seal_riff();
        play_file();
        settle();
    endtask

    task automatic test_early_end();
        wav_bytes.delete();
        wav_bytes.push_back(8'h52);
        play_file();
        start_file(TAG_RIFF, 32'd0, TAG_WAVE);
        push_chunk(TAG_FMT, 32'd16, 16);
        push_chunk(TAG_DATA, 32'd8, 0);
        wav_bytes = wav_bytes[0:wav_bytes.size() - 3];
        seal_riff();
        play_file();
        settle();
    endtask

    task automatic test_repeats_and_padding();
        // empty data is skipped, later data counts; second fmt is ignored
        start_file(TAG_RIFF, 32'd0, TAG_WAVE);
        push_chunk(TAG_DATA, 32'd0, 0);
        push_chunk(TAG_FMT, 32'd16, 16);
        push_chunk(TAG_FMT, 32'd20, 20);
        push_chunk(32'h6B6E_756A, 32'd3, 4);
        push_chunk(TAG_DATA, 32'd5, 6);
        seal_riff();
        play_file();
        // largest length pads to 2^32 bytes; the file runs out first
        start_file(TAG_RIFF, 32'hFFFF_FFFF, TAG_WAVE);
        push_chunk(32'h6B6E_756A, 32'hFFFF_FFFF, 6);
        play_file();
        settle();
    endtask

    task automatic test_register_settings();
        // nothing wanted: the walk runs to its end
        apply_settings(1'b0, 1'b0);
        start_file(TAG_RIFF, 32'd0, TAG_WAVE);
        push_chunk(TAG_FMT, 32'd16, 16);
        push_chunk(TAG_DATA, 32'd2, 2);
        seal_riff();
        play_file();
        settle();
        // fmt only: decided as soon as fmt is seen
        apply_settings(1'b1, 1'b0);
        start_file(TAG_RIFF, 32'd0, TAG_WAVE);
        push_chunk(TAG_DATA, 32'd2, 2);
        push_chunk(TAG_FMT, 32'd16, 16);
        seal_riff();
        play_file();
        settle();
        // data only: a short fmt is not wanted and is skipped
        apply_settings(1'b0, 1'b1);
        start_file(TAG_RIFF, 32'd0, TAG_WAVE);
        push_chunk(TAG_FMT, 32'd4, 4);
        push_chunk(TAG_DATA, 32'd7, 8);
        seal_riff();
        play_file();
        settle();
        apply_settings(1'b1, 1'b1);
    endtask

    // Hold the receiver off while short files keep deciding, so that
    // the output register fills and the input stalls.
    task automatic test_backpressure();
        src_calm = 1'b1;
        rx_hold  = 300;
        repeat (6) begin
            start_file(TAG_RIFF, 32'($urandom), TAG_WAVE ^ {$urandom} ^ 32'h1);
            play_file();
        end
        settle();
        src_calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Random files: mostly well formed with random chunk lists, the rest
    // noise, bad tags, odd RIFF lengths, truncation and trailing junk.
    // ------------------------------------------------------------------
    function automatic void build_random_file();
        int          pick;
        int          total;
        int          k;
        logic [31:0] tag;
        logic [31:0] len;
        logic [31:0] riff_len;
        wav_bytes.delete();
        if ($urandom_range(0, 99) < 6) begin
            repeat ($urandom_range(1, 20)) wav_bytes.push_back(8'($urandom));
            return;
        end
        start_file(TAG_RIFF, 32'd0, TAG_WAVE);
        repeat ($urandom_range(1, 4)) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                tag = TAG_FMT;
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 13)
                                                  : $urandom_range(14, 24);
            end else if (pick < 6) begin
                tag = TAG_DATA;
                len = ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom_range(1, 24);
            end else if (pick < 8) begin
                tag = $urandom;
                len = $urandom_range(0, 9);
            end else begin
                // near miss of a known tag
                tag = (pick == 8 ? TAG_FMT : TAG_DATA) ^ (32'd1 << $urandom_range(0, 31));
                len = $urandom_range(0, 9);
            end
            push_chunk(tag, len, int'((len + 32'd1) & ~32'd1));
        end
        total = wav_bytes.size();
        pick  = $urandom_range(0, 99);
        if (pick < 70) riff_len = 32'(total - 8);
        else if (pick < 85) riff_len = $urandom_range(4, total);
        else riff_len = $urandom;
        for (int i = 0; i < 4; i++) wav_bytes[4 + i] = riff_len[8*i +: 8];
        if ($urandom_range(0, 99) < 10) begin
            k = $urandom_range(0, 11);
            wav_bytes[k] = wav_bytes[k] ^ (8'd1 << $urandom_range(0, 7));
        end
        if ($urandom_range(0, 99) < 8)
            push_chunk($urandom, 32'hFFFF_FFFF, $urandom_range(0, 6));
        if ($urandom_range(0, 99) < 15)
            wav_bytes = wav_bytes[0:$urandom_range(0, wav_bytes.size() - 1)];
        if ($urandom_range(0, 99) < 20)
            repeat ($urandom_range(1, 6)) wav_bytes.push_back(8'($urandom));
    endfunction

    task automatic test_random_files();
        int first_byte;
        first_byte = bytes_sent;
        while (bytes_sent - first_byte < 150) begin
            if ($urandom_range(0, 9) == 0) begin
                // registers change only with the block idle
                settle();
                if ($urandom_range(0, 9) < 6) apply_settings(1'b1, 1'b1);
                else apply_settings(1'($urandom), 1'($urandom));
            end
            src_calm = ($urandom_range(0, 4) == 0);
            build_random_file();
            play_file();
        end
        src_calm = 1'b0;
        settle();
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial begin : test_sequence
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        apply_settings(1'b1, 1'b1);
        test_well_formed();
        test_bad_tags();
        test_short_format();
        test_walk_end();
        test_early_end();
        test_repeats_and_padding();
        test_register_settings();
        test_backpressure();
        test_random_files();

        $display("Covered %0d files, %0d bytes, %0d register settings, %0d results checked.",
                 files_played, bytes_sent, settings_used, verdicts_seen);
        $display("Statuses seen: ok %0d, bad tags %0d, short fmt %0d, not found %0d, truncated %0d.",
                 status_tally[ST_OK], status_tally[ST_NOT_RIFF], status_tally[ST_FMT_SHORT],
                 status_tally[ST_NOT_FOUND], status_tally[ST_TRUNCATED]);
        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin : watchdog
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/rwcl_pkg.sv
src/rwcl_walker.sv
src/riff_wave_chunk_locator_core.sv
verif/riff_wave_chunk_locator_core_tb.sv
